### rtl/core/p6vs_pkg.sv
// ----------------------------------------------------------------------------
// p6vs_pkg
// Shared widths, types and saturation helpers for the degree-6 polynomial
// value and slope evaluator.
// ----------------------------------------------------------------------------
package p6vs_pkg;

  // data format and sizes
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int NUM_COEF  = 7;
  localparam int NUM_STEPS = NUM_COEF - 1;
  localparam int PIPE_LAT  = 2 * NUM_STEPS;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = IDX_W + 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = PROD_W + 1;

  localparam logic [IDX_W-1:0] NUM_REGS = IDX_W'(NUM_COEF);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // saturated value with its clip flag
  typedef struct packed {
    data_t val;
    logic  clip;
  } sat_t;

  // coefficient set seen by the datapath
  typedef struct packed {
    data_t [NUM_COEF-1:0]  coef;
    data_t [NUM_STEPS-1:0] slope_coef;
    logic                  slope_clip;
  } coef_set_t;

  // one beat traveling down the horner chain
  typedef struct packed {
    logic  vld;
    data_t x;
    data_t vacc;
    data_t sacc;
    logic  vclip;
    logic  sclip;
  } beat_t;

  localparam wide_t WIDE_MAX   = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam wide_t WIDE_MIN   = ~WIDE_MAX;
  localparam wide_t ROUND_HALF = (FRAC_W > 0) ? (wide_t'(1) << ((FRAC_W > 0) ? FRAC_W - 1 : 0))
                                              : wide_t'(0);

  // clamp a wide value to the data range
  function automatic sat_t sat_wide(input wide_t v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[DATA_W-1:0];
    if (v > WIDE_MAX) begin
      r.val  = WIDE_MAX[DATA_W-1:0];
      r.clip = 1'b1;
    end else if (v < WIDE_MIN) begin
      r.val  = WIDE_MIN[DATA_W-1:0];
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

### rtl/core/p6vs_cfg.sv
// ----------------------------------------------------------------------------
// p6vs_cfg
// Coefficient register file on the apb port, plus the derivative
// coefficients (scaled by 6 down to 1) kept in registers.
// ----------------------------------------------------------------------------
module p6vs_cfg
  import p6vs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output coef_set_t         cfg_o
);

  data_t [NUM_COEF-1:0]  coef_q, coef_d;
  data_t [NUM_STEPS-1:0] scl_q, scl_d;
  logic                  clip_q, clip_d;
  logic [IDX_W-1:0]      idx;
  logic                  wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;

  // register writes, indexes past the list are dropped
  always_comb begin
    coef_d = coef_q;
    if (wr_en && (idx < NUM_REGS)) begin
      coef_d[idx] = pwdata;
    end
  end

  // derivative coefficients: k * c with k from 6 down to 1,
  // taken from the next coefficient values so both load on the same edge
  always_comb begin
    sat_t s;
    clip_d = 1'b0;
    scl_d  = scl_q;
    for (int k = 0; k < NUM_STEPS; k++) begin
      s        = sat_wide(wide_t'(coef_d[k]) * wide_t'(NUM_STEPS - k));
      scl_d[k] = s.val;
      clip_d   = clip_d | s.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      scl_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      coef_q <= coef_d;
      scl_q  <= scl_d;
      clip_q <= clip_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (idx < NUM_REGS) begin
      prdata = coef_q[idx];
    end
  end

  assign cfg_o.coef       = coef_q;
  assign cfg_o.slope_coef = scl_q;
  assign cfg_o.slope_clip = clip_q;

endmodule

### rtl/core/p6vs_step.sv
// ----------------------------------------------------------------------------
// p6vs_step
// One horner step for both lanes: a multiplier stage, then a round,
// saturate and add stage. In pass mode the slope lane only rides along.
// ----------------------------------------------------------------------------
module p6vs_step
  import p6vs_pkg::*;
#(
  parameter bit SLOPE_PASS = 1'b0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  beat_t beat_i,
  input  data_t vadd_i,
  input  data_t sadd_i,
  output beat_t beat_o
);

  typedef struct packed {
    logic  vld;
    data_t x;
    prod_t vprod;
    prod_t sprod;
    logic  vclip;
    logic  sclip;
  } mid_t;

  mid_t  mid_d, mid_q;
  beat_t out_d, out_q;

  // round to nearest, clamp, then saturating add
  function automatic sat_t round_add(input prod_t p, input data_t a);
    wide_t rnd;
    sat_t  m;
    sat_t  s;
    rnd    = (wide_t'(p) + ROUND_HALF) >>> FRAC_W;
    m      = sat_wide(rnd);
    s      = sat_wide(wide_t'(m.val) + wide_t'(a));
    s.clip = s.clip | m.clip;
    return s;
  endfunction

  // multiplier stage; pass mode pre-scales so the rounding gives acc back
  always_comb begin
    mid_d.vld   = beat_i.vld;
    mid_d.x     = beat_i.x;
    mid_d.vprod = beat_i.vacc * beat_i.x;
    if (SLOPE_PASS) begin
      mid_d.sprod = prod_t'(beat_i.sacc) <<< FRAC_W;
    end else begin
      mid_d.sprod = beat_i.sacc * beat_i.x;
    end
    mid_d.vclip = beat_i.vclip;
    mid_d.sclip = beat_i.sclip;
  end

  // round and add stage
  always_comb begin
    sat_t v;
    sat_t s;
    v           = round_add(mid_q.vprod, vadd_i);
    s           = round_add(mid_q.sprod, sadd_i);
    out_d.vld   = mid_q.vld;
    out_d.x     = mid_q.x;
    out_d.vacc  = v.val;
    out_d.sacc  = s.val;
    out_d.vclip = mid_q.vclip | v.clip;
    out_d.sclip = mid_q.sclip | s.clip;
  end

  // stage registers: valid bits every cycle, payload only with a live beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      out_q <= '0;
    end else begin
      mid_q.vld <= mid_d.vld;
      out_q.vld <= out_d.vld;
      if (mid_d.vld) begin
        mid_q.x     <= mid_d.x;
        mid_q.vprod <= mid_d.vprod;
        mid_q.sprod <= mid_d.sprod;
        mid_q.vclip <= mid_d.vclip;
        mid_q.sclip <= mid_d.sclip;
      end
      if (out_d.vld) begin
        out_q.x     <= out_d.x;
        out_q.vacc  <= out_d.vacc;
        out_q.sacc  <= out_d.sacc;
        out_q.vclip <= out_d.vclip;
        out_q.sclip <= out_d.sclip;
      end
    end
  end

  assign beat_o = out_q;

endmodule

### rtl/core/poly6_value_and_slope_top.sv
// An accepted start comes out as a done_o strobe from the last step register.
// Throughput: one point per cycle; busy stays low and results cannot be held.
// The pipeline is six horner steps of two register stages each
// (a 32x32 multiplier stage, then a round, saturate and add stage).
// Reset clears the pipeline valid bits and all coefficients to zero.
// ----------------------------------------------------------------------------
// poly6_value_and_slope_top
// Degree-6 polynomial value and first derivative in signed Q16.16, with
// saturation flags, evaluated by a pipelined horner chain.
// ----------------------------------------------------------------------------
module poly6_value_and_slope_top
  import p6vs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] abscissa_i,
  // result side
  output logic              done_o,
  output logic [DATA_W-1:0] curve_value_o,
  output logic [DATA_W-1:0] curve_slope_o,
  output logic              value_clipped_o,
  output logic              slope_clipped_o,
  // apb configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  coef_set_t cfg;
  beat_t     chain [0:NUM_STEPS];
  data_t     sadd  [0:NUM_STEPS-1];

  assign pready = 1'b1;
  assign busy   = 1'b0;

  p6vs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // beat entering the chain: leading coefficients seed both lanes
  always_comb begin
    chain[0].vld   = start & ~busy;
    chain[0].x     = abscissa_i;
    chain[0].vacc  = cfg.coef[0];
    chain[0].sacc  = cfg.slope_coef[0];
    chain[0].vclip = 1'b0;
    chain[0].sclip = cfg.slope_clip;
  end

  // horner chain
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    if (i == NUM_STEPS - 1) begin : g_pass
      assign sadd[i] = '0;
    end else begin : g_add
      assign sadd[i] = cfg.slope_coef[i+1];
    end

    p6vs_step #(
      .SLOPE_PASS (i == NUM_STEPS - 1)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .beat_i (chain[i]),
      .vadd_i (cfg.coef[i+1]),
      .sadd_i (sadd[i]),
      .beat_o (chain[i+1])
    );
  end

  // result beat straight from the last step register
  assign done_o          = chain[NUM_STEPS].vld;
  assign curve_value_o   = chain[NUM_STEPS].vacc;
  assign curve_slope_o   = chain[NUM_STEPS].sacc;
  assign value_clipped_o = chain[NUM_STEPS].vclip;
  assign slope_clipped_o = chain[NUM_STEPS].sclip;

endmodule

### rtl/core/p6vs_checker.sv
// ----------------------------------------------------------------------------
// p6vs_checker
// Port-level checks for the polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module p6vs_checker
  import p6vs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  logic wr_hit;

  assign wr_hit = psel & penable & pwrite & pready & (paddr[ADDR_W-1:2] < NUM_REGS);

  // every accepted point gives a result after the pipeline latency
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT done_o)
    else $error("accepted point gave no result");

  // no result beat without a point accepted the latency before
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without an accepted point");

  // a written coefficient reads back on the next read of the same address
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_hit ##1 (psel && !pwrite && (paddr == $past(paddr)))
      |-> (prdata == $past(pwdata)))
    else $error("coefficient read back differs from the write");

endmodule

bind poly6_value_and_slope_top p6vs_checker u_p6vs_checker (.*);

### dv/tb_poly6_value_and_slope_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_poly6_value_and_slope_top
// Self-checking bench for the degree-6 polynomial value and slope evaluator.
// Coefficients are loaded over the register port, points are sent as start
// beats, and every done beat is compared against a bit-accurate horner model
// with per-step rounding and saturation, run at the moment each point is taken.
// ----------------------------------------------------------------------------
module tb_poly6_value_and_slope_top;
  import p6vs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = PIPE_LAT + 4;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_SETS      = 4;
  localparam int POINTS_PER_SET = 96;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  localparam data_t Q_ONE     = 32'sh0001_0000;
  localparam data_t Q_HALF    = 32'sh0000_8000;
  localparam data_t Q_TWO     = 32'sh0002_0000;
  localparam data_t DATA_MAX  = 32'sh7fff_ffff;
  localparam data_t DATA_MIN  = 32'sh8000_0000;

  // register map, one word per coefficient
  typedef enum int {
    COEF_X6 = 0,
    COEF_X5,
    COEF_X4,
    COEF_X3,
    COEF_X2,
    COEF_X1,
    COEF_X0,
    COEF_NONE
  } coef_idx_e;

  typedef struct {
    data_t value;
    data_t slope;
    logic  vclip;
    logic  sclip;
  } curve_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] abscissa_i;
  logic              done_o;
  logic [DATA_W-1:0] curve_value_o;
  logic [DATA_W-1:0] curve_slope_o;
  logic              value_clipped_o;
  logic              slope_clipped_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  data_t  coef_q [NUM_COEF];
  curve_t pending_curves [$];
  curve_t due_curve;
  int     mismatch_cnt = 0;
  int     quiet_cycles = 0;
  int     gap_pct      = 0;

  poly6_value_and_slope_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .abscissa_i     (abscissa_i),
    .done_o         (done_o),
    .curve_value_o  (curve_value_o),
    .curve_slope_o  (curve_slope_o),
    .value_clipped_o(value_clipped_o),
    .slope_clipped_o(slope_clipped_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // clamp to the data range, sticky clip flag
  function automatic longint clamp_q(input logic signed [127:0] v, inout bit clip);
    if (v > Q_MAX) begin
      clip = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      clip = 1'b1;
      return Q_MIN;
    end
    return longint'(v);
  endfunction

  // exact product, round half up, arithmetic shift, saturate
  function automatic longint round_mul(input longint a, input longint b, input int sh,
                                       inout bit clip);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    if (sh > 0) p = p + (128'sd1 <<< (sh - 1));
    p = p >>> sh;
    return clamp_q(p, clip);
  endfunction

  function automatic longint add_clip(input longint a, input longint b, inout bit clip);
    logic signed [127:0] s;
    s = a;
    s = s + b;
    return clamp_q(s, clip);
  endfunction

  // value and slope by horner's rule with the current coefficients
  function automatic curve_t eval_curve(input data_t x);
    longint acc;
    longint scaled;
    longint xs;
    bit     vc;
    bit     sc;
    curve_t r;
    xs  = x;
    vc  = 1'b0;
    sc  = 1'b0;
    acc = coef_q[COEF_X6];
    for (int i = 1; i < NUM_COEF; i++)
      acc = add_clip(round_mul(acc, xs, FRAC_W, vc), coef_q[i], vc);
    r.value = data_t'(acc);
    acc = round_mul(coef_q[COEF_X6], NUM_STEPS, 0, sc);
    for (int i = 1; i < NUM_STEPS; i++) begin
      scaled = round_mul(coef_q[i], NUM_STEPS - i, 0, sc);
      acc    = add_clip(round_mul(acc, xs, FRAC_W, sc), scaled, sc);
    end
    r.slope = data_t'(acc);
    r.vclip = vc;
    r.sclip = sc;
    return r;
  endfunction

  // signed value within +-span, or any 32-bit word when span is zero
  function automatic data_t rand_q(input int span);
    int v;
    if (span == 0) return data_t'($urandom);
    v = int'($urandom_range(2 * span)) - span;
    return data_t'(v);
  endfunction

  function automatic data_t rand_point();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) return rand_q(0);
    if (sel < 30) return rand_q(32'h4000);
    return rand_q(32'h3_0000);
  endfunction

  task automatic report(input string what, input longint expv, input longint actv);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch %0d at %0t: %s expected %h got %h",
               mismatch_cnt, $realtime, what, expv, actv);
  endtask

  // one point beat, with a random gap ahead of it
  task automatic send_point(input data_t x);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    abscissa_i <= x;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_curves.push_back(eval_curve(x));
  endtask

  // stop sending and let the pipeline empty
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_curves.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input coef_idx_e idx, input data_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx != COEF_NONE) coef_q[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read_check(input coef_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== coef_q[idx]) report($sformatf("readback %s", idx.name()),
                                       coef_q[idx], prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(input data_t c [NUM_COEF]);
    drain_pipeline();
    for (int i = 0; i < NUM_COEF; i++) reg_write(coef_idx_e'(i), c[i]);
  endtask

  task automatic send_points(input data_t pts [$]);
    foreach (pts[i]) send_point(pts[i]);
  endtask

  // reset values: all coefficients read zero and every point maps to zero
  task automatic test_reset_values();
    data_t pts [$];
    for (int i = 0; i < NUM_COEF; i++) reg_read_check(coef_idx_e'(i));
    pts = '{32'sh0, DATA_MAX, DATA_MIN};
    send_points(pts);
  endtask

  // register port: extremes and random words read back, unused slot ignored
  task automatic test_register_access();
    drain_pipeline();
    for (int i = 0; i < NUM_COEF; i++)
      reg_write(coef_idx_e'(i), (i % 2) ? DATA_MIN : DATA_MAX);
    for (int i = 0; i < NUM_COEF; i++) reg_read_check(coef_idx_e'(i));
    for (int i = 0; i < NUM_COEF; i++) reg_write(coef_idx_e'(i), rand_q(0));
    reg_write(COEF_NONE, rand_q(0));
    for (int i = 0; i < NUM_COEF; i++) reg_read_check(coef_idx_e'(i));
  endtask

  // directed points: field extremes, rounding ties, clipping corners
  task automatic test_directed_points();
    data_t cs [NUM_COEF];
    data_t pts [$];

    // unit coefficients over the interesting abscissas
    cs = '{default: Q_ONE};
    load_coefs(cs);
    pts = '{32'sh0, 32'sh1, -32'sh1, DATA_MAX, DATA_MIN, Q_ONE, -Q_ONE, Q_HALF, -Q_HALF};
    send_points(pts);

    // all coefficients at the top, then the bottom of the range
    cs = '{default: DATA_MAX};
    load_coefs(cs);
    pts = '{DATA_MAX, DATA_MIN, Q_ONE};
    send_points(pts);
    cs = '{default: DATA_MIN};
    load_coefs(cs);
    pts = '{-Q_ONE, Q_HALF};
    send_points(pts);

    // chain clips early, constant term pulls it back in range, flag stays
    cs = '{DATA_MAX, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, DATA_MIN};
    load_coefs(cs);
    pts = '{Q_TWO, 32'sh0};
    send_points(pts);

    // scaling the top coefficient by six overflows on the slope side
    cs = '{32'sh2000_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    load_coefs(cs);
    send_point(32'sh0);

    // exact half lsb ties round toward plus infinity
    cs = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0};
    load_coefs(cs);
    pts = '{Q_HALF, -Q_HALF};
    send_points(pts);

    // write to the unused slot leaves the coefficients alone
    drain_pipeline();
    reg_write(COEF_NONE, DATA_MAX);
    send_point(Q_HALF);
  endtask

  // random coefficient sets and points under several sender gap rates
  task automatic test_random_points();
    int    gap_rates [3];
    data_t cs [NUM_COEF];
    gap_rates = '{0, 51, 33};
    foreach (gap_rates[p]) begin
      for (int s = 0; s < RAND_SETS; s++) begin
        for (int i = 0; i < NUM_COEF; i++) begin
          case (s)
            0: cs[i] = rand_q(32'h2_0000);
            1: cs[i] = (i == COEF_X0) ? rand_q(0) : rand_q(32'h1000);
            2: cs[i] = rand_q(0);
            default: begin
              case ($urandom_range(3))
                0: cs[i] = DATA_MAX;
                1: cs[i] = DATA_MIN;
                2: cs[i] = 32'sh0;
                default: cs[i] = rand_q(32'h8000);
              endcase
            end
          endcase
        end
        load_coefs(cs);
        gap_pct = gap_rates[p];
        for (int n = 0; n < POINTS_PER_SET; n++) send_point(rand_point());
      end
    end
    gap_pct = 0;
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_curves.size() == 0) begin
        report("result with nothing pending", 0, curve_value_o);
      end else begin
        due_curve = pending_curves.pop_front();
        if (curve_value_o !== due_curve.value)
          report("curve_value", due_curve.value, curve_value_o);
        if (curve_slope_o !== due_curve.slope)
          report("curve_slope", due_curve.slope, curve_slope_o);
        if (value_clipped_o !== due_curve.vclip)
          report("value_clipped", due_curve.vclip, value_clipped_o);
        if (slope_clipped_o !== due_curve.sclip)
          report("slope_clipped", due_curve.sclip, slope_clipped_o);
      end
    end
  end

  // watchdog on cycles without any beat or register transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    abscissa_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    for (int i = 0; i < NUM_COEF; i++) coef_q[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_register_access();
    test_directed_points();
    test_random_points();
    drain_pipeline();

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
